// ===== rtl/core/epa_pkg.sv =====
`timescale 1ns / 1ps
// Shared codes, widths and record types for the error-propagation ALU.
// No dependencies; used by error_propagation_alu and epa_checker.
package epa_pkg;

  // Operation codes
  localparam logic [2:0] CMD_NEG = 3'd0;
  localparam logic [2:0] CMD_ADD = 3'd1;
  localparam logic [2:0] CMD_SUB = 3'd2;
  localparam logic [2:0] CMD_MUL = 3'd3;
  localparam logic [2:0] CMD_DIV = 3'd4;
  localparam logic [2:0] CMD_CHI = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CHI_VAR  = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_SAT      = 2'd3;

  localparam int unsigned QDIV_STEPS = 32;  // value / chi-square quotient bits
  localparam int unsigned TDIV_STEPS = 34;  // variance term quotient bits
  localparam int unsigned SQ_W       = 63;  // square of a 32-bit magnitude
  localparam int unsigned TERM_W     = 34;
  localparam logic [TERM_W-1:0] TERM_CAP = 34'h2_0000_0000;
  localparam int unsigned PIPE_LAT   = 76;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        late;      // result comes from the divider path
    logic [31:0] value;
    logic [31:0] variance;
    logic [1:0]  status;
    logic        neg_q;     // sign of a*b or a/b
    logic        neg_t1;    // sign of a_variance
    logic        neg_t2;    // sign of b_variance
    logic [31:0] mbv;       // magnitude of b_variance
  } early_t;

  typedef struct packed {
    logic [32:0]       r;   // {saturated, quotient value}
    logic [TERM_W-1:0] t1;
  } late_t;

endpackage

// ===== rtl/core/epa_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on nothing; instantiated by error_propagation_alu.
module epa_div #(
  parameter int unsigned NUM_W = 65,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned STEPS = 32
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [STEPS-1:0] quo_o,
  output logic             big_o   // quotient does not fit in STEPS bits
);

  localparam int unsigned HI_W = NUM_W - STEPS;

  logic [DEN_W-1:0]      rem_q  [0:STEPS];
  logic [STEPS-1:0]      bits_q [0:STEPS];
  logic [DEN_W-1:0]      den_q  [0:STEPS];
  logic                  big_q  [0:STEPS];
  logic [DEN_W:0]        trial  [0:STEPS-1];
  logic                  take   [0:STEPS-1];
  logic [DEN_W-1:0]      rem_d  [0:STEPS-1];
  logic [HI_W+DEN_W-1:0] hi_ext, den_ext;

  assign hi_ext  = {{DEN_W{1'b0}}, num_i[NUM_W-1:STEPS]};
  assign den_ext = {{HI_W{1'b0}}, den_i};

  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      trial[k] = {rem_q[k], bits_q[k][STEPS-1]};
      take[k]  = trial[k] >= {1'b0, den_q[k]};
      rem_d[k] = take[k] ? DEN_W'(trial[k] - {1'b0, den_q[k]}) : trial[k][DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= hi_ext[DEN_W-1:0];
    bits_q[0] <= num_i[STEPS-1:0];
    den_q[0]  <= den_i;
    big_q[0]  <= hi_ext >= den_ext;
    for (int k = 0; k < STEPS; k++) begin
      rem_q[k+1]  <= rem_d[k];
      bits_q[k+1] <= {bits_q[k][STEPS-2:0], take[k]};
      den_q[k+1]  <= den_q[k];
      big_q[k+1]  <= big_q[k];
    end
  end

  assign quo_o = bits_q[STEPS];
  assign big_o = big_q[STEPS];

endmodule

// ===== rtl/core/error_propagation_alu.sv =====
`timescale 1ns / 1ps
// Top level of the error-propagation ALU: value/variance arithmetic in fixed point.
// Depends on epa_pkg and epa_div.
//
// Usage:
//   Command channel: drive cmd_i and the two value/variance pairs and raise
//   start. A transaction is taken at every rising edge with start high and
//   busy low. busy stays low: the datapath is a fixed-length pipeline with
//   no feedback, so a new transaction may enter in every cycle.
//   Result channel: done_o is high for exactly one cycle with out_value_o,
//   out_variance_o and status_o. The receiver cannot stall, so nothing is
//   held back; results leave in the order the transactions entered.
//   Results of every opcode leave from the same last stage. Throughput:
//   one transaction per cycle. The pipeline length is set by the divide
//   path: a 32-step quotient divider, the square of the quotient, then a
//   34-step variance-term divider, each divider retiring one quotient bit
//   per stage.
//   Reset: rst_ni clears the valid pipeline only; transactions in flight
//   are dropped and no strobe follows. Payload registers are not reset.
module error_propagation_alu #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] a_value_i,
  input  logic signed [31:0] a_variance_i,
  input  logic signed [31:0] b_value_i,
  input  logic signed [31:0] b_variance_i,
  output logic               done_o,
  output logic signed [31:0] out_value_o,
  output logic signed [31:0] out_variance_o,
  output logic [1:0]         status_o
);
  import epa_pkg::*;

  // Numerator widths of the dividers
  localparam int unsigned NQ_W = (32 + FRAC_BITS > 65) ? 32 + FRAC_BITS : 65;
  localparam int unsigned NT_W = (32 + 2 * FRAC_BITS > 94) ? 32 + 2 * FRAC_BITS : 94;

  // Stage numbers: stage 1 is loaded at the accepting edge, stage k after stage k-1
  localparam int unsigned S_QIN  = 3;
  localparam int unsigned S_MUL  = 6;
  localparam int unsigned S_QOUT = S_QIN + QDIV_STEPS + 1;
  localparam int unsigned S_T1   = S_QIN + TDIV_STEPS + 1;
  localparam int unsigned S_T2IN = S_T1 + 2;
  localparam int unsigned LAST   = S_T2IN + TDIV_STEPS + 1;

  localparam logic [31:0] CHI_ERR = 32'd0 - (32'd1 << FRAC_BITS);

  // ---------------------------------------------------------------- helpers
  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  // {saturated, value} of a 33-bit signed sum
  function automatic logic [32:0] sat33(input logic [32:0] v);
    if (v[32] != v[31]) begin
      return {1'b1, v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end
    return {1'b0, v[31:0]};
  endfunction

  // {saturated, value} of a signed magnitude
  function automatic logic [32:0] sat_mag(input logic [63:0] p, input logic neg);
    if (neg) begin
      if (p > 64'h8000_0000) return {1'b1, 32'h8000_0000};
      return {1'b0, ~p[31:0] + 32'd1};
    end
    if (p > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, p[31:0]};
  endfunction

  function automatic logic [TERM_W-1:0] cap_wide(input logic [NT_W-1:0] v);
    return (v > NT_W'(TERM_CAP)) ? TERM_CAP : v[TERM_W-1:0];
  endfunction

  function automatic logic [TERM_W-1:0] cap_quo(input logic big, input logic [TERM_W-1:0] q);
    return (big || q > TERM_CAP) ? TERM_CAP : q;
  endfunction

  // {saturated, value} of two signed variance terms added
  function automatic logic [32:0] sum_terms(input logic [TERM_W-1:0] t1, input logic n1,
                                            input logic [TERM_W-1:0] t2, input logic n2);
    logic [35:0] s1, s2, s;
    s1 = n1 ? (36'd0 - {2'b00, t1}) : {2'b00, t1};
    s2 = n2 ? (36'd0 - {2'b00, t2}) : {2'b00, t2};
    s  = s1 + s2;
    if (s[35:31] == 5'b00000 || s[35:31] == 5'b11111) return {1'b0, s[31:0]};
    return {1'b1, s[35] ? 32'h8000_0000 : 32'h7FFF_FFFF};
  endfunction

  // ---------------------------------------------------------------- valid line
  logic [LAST:0] vld_q;
  logic          accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAST-1:0], accept};
    end
  end

  // ---------------------------------------------------------------- stage 1: capture
  logic [2:0]  s1_cmd_q;
  logic [31:0] s1_a_q, s1_av_q, s1_b_q, s1_bv_q;

  always_ff @(posedge clk_i) begin
    s1_cmd_q <= cmd_i;
    s1_a_q   <= a_value_i;
    s1_av_q  <= a_variance_i;
    s1_b_q   <= b_value_i;
    s1_bv_q  <= b_variance_i;
  end

  // ---------------------------------------------------------------- stage 2: magnitudes, simple ops
  early_t      e_q [2:LAST];
  early_t      e2_d, e6_d;
  logic [32:0] diff, neg_r, add_r, sub_r, var_r;
  logic [32:0] s2_md_q;
  logic [31:0] s2_ma_q, s2_mb_q, s2_mav_q;

  always_comb begin
    diff  = {s1_b_q[31], s1_b_q} - {s1_a_q[31], s1_a_q};
    neg_r = sat33(33'd0 - {s1_a_q[31], s1_a_q});
    add_r = sat33({s1_a_q[31], s1_a_q} + {s1_b_q[31], s1_b_q});
    sub_r = sat33({s1_a_q[31], s1_a_q} - {s1_b_q[31], s1_b_q});
    var_r = sat33({s1_av_q[31], s1_av_q} + {s1_bv_q[31], s1_bv_q});

    e2_d          = '0;
    e2_d.cmd      = s1_cmd_q;
    e2_d.neg_q    = s1_a_q[31] ^ s1_b_q[31];
    e2_d.neg_t1   = s1_av_q[31];
    e2_d.neg_t2   = s1_bv_q[31];
    e2_d.mbv      = mag32(s1_bv_q);
    case (s1_cmd_q)
      CMD_NEG: begin
        e2_d.value    = neg_r[31:0];
        e2_d.variance = s1_av_q;
        e2_d.status   = neg_r[32] ? ST_SAT : ST_OK;
      end
      CMD_ADD: begin
        e2_d.value    = add_r[31:0];
        e2_d.variance = var_r[31:0];
        e2_d.status   = (add_r[32] || var_r[32]) ? ST_SAT : ST_OK;
      end
      CMD_SUB: begin
        e2_d.value    = sub_r[31:0];
        e2_d.variance = var_r[31:0];
        e2_d.status   = (sub_r[32] || var_r[32]) ? ST_SAT : ST_OK;
      end
      CMD_DIV: begin
        if (s1_b_q == 32'd0) begin
          e2_d.status = ST_DIV_ZERO;
        end else begin
          e2_d.late = 1'b1;
        end
      end
      CMD_CHI: begin
        if (s1_av_q[31] || s1_av_q == 32'd0) begin
          e2_d.value  = CHI_ERR;
          e2_d.status = ST_CHI_VAR;
        end else begin
          e2_d.late = 1'b1;
        end
      end
      default: ;  // multiply is filled in later, unused codes give zeros
    endcase
  end

  always_ff @(posedge clk_i) begin
    s2_ma_q  <= mag32(s1_a_q);
    s2_mb_q  <= mag32(s1_b_q);
    s2_mav_q <= mag32(s1_av_q);
    s2_md_q  <= diff[32] ? (~diff + 33'd1) : diff;
  end

  // ---------------------------------------------------------------- stage 3: squares and products
  logic [SQ_W-1:0] sq_q [S_QIN:S_T2IN];   // b squared, held for both term dividers
  logic [63:0]     s3_pab_q;
  logic [SQ_W-1:0] s3_a2_q;
  logic [64:0]     s3_d2_q;
  logic [31:0]     s3_ma_q, s3_mb_q, s3_mav_q;
  logic [63:0]     b2_full, a2_full;
  logic [65:0]     d2_full;

  assign b2_full = 64'(s2_mb_q) * 64'(s2_mb_q);
  assign a2_full = 64'(s2_ma_q) * 64'(s2_ma_q);
  assign d2_full = 66'(s2_md_q) * 66'(s2_md_q);

  always_ff @(posedge clk_i) begin
    s3_pab_q <= 64'(s2_ma_q) * 64'(s2_mb_q);
    s3_a2_q  <= a2_full[SQ_W-1:0];
    s3_d2_q  <= d2_full[64:0];
    s3_ma_q  <= s2_ma_q;
    s3_mb_q  <= s2_mb_q;
    s3_mav_q <= s2_mav_q;
    sq_q[S_QIN] <= b2_full[SQ_W-1:0];
    for (int k = S_QIN + 1; k <= S_T2IN; k++) begin
      sq_q[k] <= sq_q[k-1];
    end
  end

  // ---------------------------------------------------------------- stages 4-6: multiply path
  logic [63:0]       s4_h1_q, s4_h2_q;
  logic [62:0]       s4_l1_q, s4_l2_q;
  logic [32:0]       s4_mrv_q, s5_mrv_q;
  logic [TERM_W-1:0] s5_t1_q, s5_t2_q;
  logic [NT_W-1:0]   m1, m2;
  logic [32:0]       mul_var;

  always_ff @(posedge clk_i) begin
    // split the 63-bit squares so each product stays near 32 x 32
    s4_h1_q  <= 64'(s3_mav_q) * 64'(sq_q[S_QIN][SQ_W-1:31]);
    s4_l1_q  <= 63'(s3_mav_q) * 63'(sq_q[S_QIN][30:0]);
    s4_h2_q  <= 64'(e_q[3].mbv) * 64'(s3_a2_q[SQ_W-1:31]);
    s4_l2_q  <= 63'(e_q[3].mbv) * 63'(s3_a2_q[30:0]);
    s4_mrv_q <= sat_mag(s3_pab_q >> FRAC_BITS, e_q[3].neg_q);
  end

  assign m1 = (NT_W'(s4_h1_q) << 31) + NT_W'(s4_l1_q);
  assign m2 = (NT_W'(s4_h2_q) << 31) + NT_W'(s4_l2_q);

  always_ff @(posedge clk_i) begin
    s5_t1_q  <= cap_wide(m1 >> (2 * FRAC_BITS));
    s5_t2_q  <= cap_wide(m2 >> (2 * FRAC_BITS));
    s5_mrv_q <= s4_mrv_q;
  end

  always_comb begin
    mul_var = sum_terms(s5_t1_q, e_q[S_MUL-1].neg_t1, s5_t2_q, e_q[S_MUL-1].neg_t2);
    e6_d    = e_q[S_MUL-1];
    if (e_q[S_MUL-1].cmd == CMD_MUL) begin
      e6_d.value    = s5_mrv_q[31:0];
      e6_d.variance = mul_var[31:0];
      e6_d.status   = (s5_mrv_q[32] || mul_var[32]) ? ST_SAT : ST_OK;
    end
  end

  // Carry the per-transaction record down the whole pipe
  always_ff @(posedge clk_i) begin
    e_q[2] <= e2_d;
    for (int k = 3; k <= LAST; k++) begin
      if (k == S_MUL) begin
        e_q[k] <= e6_d;
      end else begin
        e_q[k] <= e_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- quotient and first term dividers
  logic [NQ_W-1:0]   qd_num;
  logic [31:0]       qd_den, qd_quo;
  logic              qd_big;
  logic [NT_W-1:0]   t1d_num;
  logic [TERM_W-1:0] t1d_quo;
  logic              t1d_big;

  // Divide: |a| << F over |b|. Chi-square: d squared over a_variance.
  assign qd_num  = (e_q[S_QIN].cmd == CMD_DIV) ? (NQ_W'(s3_ma_q) << FRAC_BITS)
                                               : NQ_W'(s3_d2_q);
  assign qd_den  = (e_q[S_QIN].cmd == CMD_DIV) ? s3_mb_q : s3_mav_q;
  assign t1d_num = NT_W'(s3_mav_q) << (2 * FRAC_BITS);

  epa_div #(.NUM_W(NQ_W), .DEN_W(32), .STEPS(QDIV_STEPS)) u_qdiv (
    .clk_i (clk_i),
    .num_i (qd_num),
    .den_i (qd_den),
    .quo_o (qd_quo),
    .big_o (qd_big)
  );

  epa_div #(.NUM_W(NT_W), .DEN_W(SQ_W), .STEPS(TDIV_STEPS)) u_t1div (
    .clk_i (clk_i),
    .num_i (t1d_num),
    .den_i (sq_q[S_QIN]),
    .quo_o (t1d_quo),
    .big_o (t1d_big)
  );

  // ---------------------------------------------------------------- quotient, its square, second term
  logic [32:0]     s37_r_q, s38_r_q;
  logic [SQ_W-1:0] s38_qq_q;
  logic [62:0]     s39_plo_q;
  logic [63:0]     s39_phi_q, qm_sq;
  logic [NT_W-1:0] s40_num_q;
  logic [31:0]     qm;
  late_t           late_q [S_T1+1:LAST];

  assign qm    = mag32(s37_r_q[31:0]);
  assign qm_sq = 64'(qm) * 64'(qm);

  always_ff @(posedge clk_i) begin
    // a quotient that overflows the divider saturates like any other
    s37_r_q  <= sat_mag(qd_big ? 64'hFFFF_FFFF_FFFF_FFFF : {32'd0, qd_quo},
                        (e_q[S_QOUT].cmd == CMD_DIV) && e_q[S_QOUT].neg_q);
    s38_r_q  <= s37_r_q;
    s38_qq_q <= qm_sq[SQ_W-1:0];
    s39_phi_q <= 64'(e_q[S_T1].mbv) * 64'(s38_qq_q[SQ_W-1:31]);
    s39_plo_q <= 63'(e_q[S_T1].mbv) * 63'(s38_qq_q[30:0]);
    s40_num_q <= (NT_W'(s39_phi_q) << 31) + NT_W'(s39_plo_q);
    late_q[S_T1+1] <= '{r: s38_r_q, t1: cap_quo(t1d_big, t1d_quo)};
    for (int k = S_T1 + 2; k <= LAST; k++) begin
      late_q[k] <= late_q[k-1];
    end
  end

  logic [TERM_W-1:0] t2d_quo;
  logic              t2d_big;

  epa_div #(.NUM_W(NT_W), .DEN_W(SQ_W), .STEPS(TDIV_STEPS)) u_t2div (
    .clk_i (clk_i),
    .num_i (s40_num_q),
    .den_i (sq_q[S_T2IN]),
    .quo_o (t2d_quo),
    .big_o (t2d_big)
  );

  // ---------------------------------------------------------------- output stage
  logic [32:0] div_var;
  logic [31:0] value_d, variance_d;
  logic [1:0]  status_d;
  logic [31:0] value_q, variance_q;
  logic [1:0]  status_q;

  always_comb begin
    div_var    = sum_terms(late_q[LAST].t1, e_q[LAST].neg_t1,
                           cap_quo(t2d_big, t2d_quo), e_q[LAST].neg_t2);
    value_d    = e_q[LAST].value;
    variance_d = e_q[LAST].variance;
    status_d   = e_q[LAST].status;
    if (e_q[LAST].late) begin
      value_d = late_q[LAST].r[31:0];
      if (e_q[LAST].cmd == CMD_DIV) begin
        variance_d = div_var[31:0];
        status_d   = (late_q[LAST].r[32] || div_var[32]) ? ST_SAT : ST_OK;
      end else begin
        // chi-square carries no variance
        variance_d = 32'd0;
        status_d   = late_q[LAST].r[32] ? ST_SAT : ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    variance_q <= variance_d;
    status_q   <= status_d;
  end

  assign done_o         = vld_q[LAST];
  assign out_value_o    = value_q;
  assign out_variance_o = variance_q;
  assign status_o       = status_q;

endmodule

// ===== rtl/core/epa_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for error_propagation_alu, attached by the bind below.
// Depends on epa_pkg.
module epa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [2:0]  cmd_i,
  input logic [31:0] a_variance_i,
  input logic [31:0] b_value_i,
  input logic        done_o,
  input logic [31:0] out_value_o,
  input logic [31:0] out_variance_o,
  input logic [1:0]  status_o
);
  import epa_pkg::*;

  // every result strobe traces back to a transaction a fixed latency earlier
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without an accepted transaction");

  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_DIV && b_value_i == 32'd0) |-> ##PIPE_LAT
    (done_o && status_o == ST_DIV_ZERO && out_value_o == 32'd0 && out_variance_o == 32'd0))
    else $error("divide by zero not reported");

  a_neg_keeps_var: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_NEG) |-> ##PIPE_LAT
    (done_o && out_variance_o == $past(a_variance_i, PIPE_LAT)))
    else $error("negate changed the variance");

  a_chi_var_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_CHI_VAR) |-> out_variance_o == 32'd0)
    else $error("chi-square error carries a variance");

endmodule

bind error_propagation_alu epa_checker u_epa_checker (.*);
